@@ hw/rtl/miller_rabin_primality_32_assert.svh @@
// assertion macros for the primality tester checker
// expects clk_i and rst_ni in the scope of use
`ifndef MILLER_RABIN_PRIMALITY_32_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_32_ASSERT_SVH

// same-cycle implication
`define MRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrp assertion failed");

// next-cycle implication
`define MRP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrp assertion failed");

`endif

@@ hw/rtl/mrp_pkg.sv @@
// shared types and constants of the primality tester
// no dependencies
package mrp_pkg;

  localparam int unsigned MRP_WIDTH = 32;
  localparam int unsigned NUM_BASES = 3;
  localparam logic [5:0] BASES [NUM_BASES] = '{6'd2, 6'd7, 6'd61};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DECOMP,
    ST_RED,
    ST_RED_W,
    ST_EXP,
    ST_ACC_W,
    ST_SQ_W,
    ST_CHK,
    ST_SQR,
    ST_SQR_W,
    ST_SQR_CHK,
    ST_PASS,
    ST_EMIT0,
    ST_EMIT1
  } state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SHIFT_D,
    OP_BASE_INIT,
    OP_SHIFT_E,
    OP_INC_J,
    OP_NEXT_BASE,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    MUL_RED,
    MUL_ACC,
    MUL_SQ,
    MUL_X
  } mul_sel_e;

  typedef struct packed {
    op_e      op;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     res;
  } ctrl_t;

  typedef struct packed {
    logic is_small;
    logic small_prime;
    logic d_even;
    logic e_zero;
    logic e_lsb;
    logic sq_zero;
    logic x_one;
    logic x_nm1;
    logic j_last;
    logic k_last;
    logic mul_busy;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/mrp_if.sv @@
// valid/ready channel interfaces for candidates and results
// no dependencies
interface mrp_cand_if #(parameter int unsigned WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface mrp_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

@@ hw/rtl/mrp_datapath.sv @@
// datapath: operand registers, bit-serial modular multiplier, result register
// depends on mrp_pkg
module mrp_datapath #(
  parameter int unsigned WIDTH = mrp_pkg::MRP_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WIDTH-1:0]  cand_i,
  input  mrp_pkg::ctrl_t    ctrl_i,
  output mrp_pkg::stat_t    stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              is_prime_o
);

  localparam int unsigned RW = $clog2(WIDTH);
  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam int unsigned KW = $clog2(mrp_pkg::NUM_BASES);

  logic [WIDTH-1:0] n_q, d_q, e_q, acc_q, sq_q, ma_q, mb_q, macc_q;
  logic [WIDTH-1:0] ma_d, mb_d, mres, base_val;
  logic [RW-1:0]    r_q, j_q;
  logic [CW-1:0]    mcnt_q;
  logic [KW-1:0]    k_q;
  logic             mdst_acc_q, mdst_acc_d;
  logic             out_valid_q, is_prime_q;
  logic [WIDTH:0]   nx, t, t2, u, u2;
  logic             mul_last;

  assign base_val = WIDTH'(mrp_pkg::BASES[k_q]);
  assign nx       = {1'b0, n_q};
  assign mul_last = (mcnt_q == CW'(1));

  always_comb begin
    t  = {macc_q, 1'b0};
    t2 = (t >= nx) ? (t - nx) : t;
    u  = t2 + (mb_q[WIDTH-1] ? {1'b0, ma_q} : '0);
    u2 = (u >= nx) ? (u - nx) : u;
    mres = u2[WIDTH-1:0];
  end

  always_comb begin
    ma_d = sq_q;
    mb_d = sq_q;
    mdst_acc_d = 1'b0;
    case (ctrl_i.mul_sel)
      mrp_pkg::MUL_RED: begin
        ma_d = WIDTH'(1);
        mb_d = base_val;
      end
      mrp_pkg::MUL_ACC: begin
        ma_d = acc_q;
        mdst_acc_d = 1'b1;
      end
      mrp_pkg::MUL_SQ: begin
        ma_d = sq_q;
      end
      mrp_pkg::MUL_X: begin
        ma_d = acc_q;
        mb_d = acc_q;
        mdst_acc_d = 1'b1;
      end
      default: begin
        ma_d = sq_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.mul_go) begin
        mcnt_q <= CW'(WIDTH);
      end else if (mcnt_q != '0) begin
        mcnt_q <= mcnt_q - CW'(1);
      end
      if (ctrl_i.op == mrp_pkg::OP_LOAD) begin
        k_q <= '0;
      end else if (ctrl_i.op == mrp_pkg::OP_NEXT_BASE) begin
        k_q <= k_q + KW'(1);
      end
      if (ctrl_i.op == mrp_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      mrp_pkg::OP_LOAD: begin
        n_q <= cand_i;
        d_q <= cand_i - WIDTH'(1);
        r_q <= '0;
      end
      mrp_pkg::OP_SHIFT_D: begin
        d_q <= d_q >> 1;
        r_q <= r_q + RW'(1);
      end
      mrp_pkg::OP_BASE_INIT: begin
        acc_q <= WIDTH'(1);
        e_q   <= d_q;
        j_q   <= RW'(1);
      end
      mrp_pkg::OP_SHIFT_E: e_q <= e_q >> 1;
      mrp_pkg::OP_INC_J:   j_q <= j_q + RW'(1);
      mrp_pkg::OP_EMIT:    is_prime_q <= ctrl_i.res;
      default: ;
    endcase
    if (ctrl_i.mul_go) begin
      ma_q       <= ma_d;
      mb_q       <= mb_d;
      macc_q     <= '0;
      mdst_acc_q <= mdst_acc_d;
    end else if (mcnt_q != '0) begin
      macc_q <= mres;
      mb_q   <= mb_q << 1;
      if (mul_last) begin
        if (mdst_acc_q) begin
          acc_q <= mres;
        end else begin
          sq_q <= mres;
        end
      end
    end
  end

  always_comb begin
    stat_o.is_small    = (n_q < WIDTH'(5)) || !n_q[0];
    stat_o.small_prime = (n_q == WIDTH'(2)) || (n_q == WIDTH'(3));
    stat_o.d_even      = !d_q[0];
    stat_o.e_zero      = (e_q == '0);
    stat_o.e_lsb       = e_q[0];
    stat_o.sq_zero     = (sq_q == '0);
    stat_o.x_one       = (acc_q == WIDTH'(1));
    stat_o.x_nm1       = (acc_q == (n_q - WIDTH'(1)));
    stat_o.j_last      = (j_q >= r_q);
    stat_o.k_last      = (k_q == KW'(mrp_pkg::NUM_BASES - 1));
    stat_o.mul_busy    = (mcnt_q != '0);
    stat_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

@@ hw/rtl/mrp_ctrl.sv @@
// controller state machine sequencing the strong probable-prime rounds
// depends on mrp_pkg
module mrp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mrp_pkg::stat_t stat_i,
  output mrp_pkg::ctrl_t ctrl_o
);

  mrp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrp_pkg::ST_IDLE:     if (in_valid_i) state_d = mrp_pkg::ST_CLASSIFY;
      mrp_pkg::ST_CLASSIFY: begin
        if (!stat_i.is_small) state_d = mrp_pkg::ST_DECOMP;
        else if (stat_i.small_prime) state_d = mrp_pkg::ST_EMIT1;
        else state_d = mrp_pkg::ST_EMIT0;
      end
      mrp_pkg::ST_DECOMP:   if (!stat_i.d_even) state_d = mrp_pkg::ST_RED;
      mrp_pkg::ST_RED:      state_d = mrp_pkg::ST_RED_W;
      mrp_pkg::ST_RED_W: begin
        if (!stat_i.mul_busy) begin
          state_d = stat_i.sq_zero ? mrp_pkg::ST_PASS : mrp_pkg::ST_EXP;
        end
      end
      mrp_pkg::ST_EXP: begin
        if (stat_i.e_zero) state_d = mrp_pkg::ST_CHK;
        else if (stat_i.e_lsb) state_d = mrp_pkg::ST_ACC_W;
        else state_d = mrp_pkg::ST_SQ_W;
      end
      mrp_pkg::ST_ACC_W:    if (!stat_i.mul_busy) state_d = mrp_pkg::ST_SQ_W;
      mrp_pkg::ST_SQ_W:     if (!stat_i.mul_busy) state_d = mrp_pkg::ST_EXP;
      mrp_pkg::ST_CHK: begin
        if (stat_i.x_one || stat_i.x_nm1) state_d = mrp_pkg::ST_PASS;
        else state_d = mrp_pkg::ST_SQR;
      end
      mrp_pkg::ST_SQR: begin
        state_d = stat_i.j_last ? mrp_pkg::ST_EMIT0 : mrp_pkg::ST_SQR_W;
      end
      mrp_pkg::ST_SQR_W:    if (!stat_i.mul_busy) state_d = mrp_pkg::ST_SQR_CHK;
      mrp_pkg::ST_SQR_CHK: begin
        if (stat_i.x_one) state_d = mrp_pkg::ST_EMIT0;
        else if (stat_i.x_nm1) state_d = mrp_pkg::ST_PASS;
        else state_d = mrp_pkg::ST_SQR;
      end
      mrp_pkg::ST_PASS: begin
        state_d = stat_i.k_last ? mrp_pkg::ST_EMIT1 : mrp_pkg::ST_RED;
      end
      mrp_pkg::ST_EMIT0,
      mrp_pkg::ST_EMIT1:    if (!stat_i.out_busy) state_d = mrp_pkg::ST_IDLE;
      default:              state_d = mrp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    ctrl_o.op      = mrp_pkg::OP_NOP;
    ctrl_o.mul_go  = 1'b0;
    ctrl_o.mul_sel = mrp_pkg::MUL_RED;
    ctrl_o.res     = 1'b0;
    unique case (state_q)
      mrp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctrl_o.op = mrp_pkg::OP_LOAD;
      end
      mrp_pkg::ST_DECOMP: if (stat_i.d_even) ctrl_o.op = mrp_pkg::OP_SHIFT_D;
      mrp_pkg::ST_RED: begin
        ctrl_o.op      = mrp_pkg::OP_BASE_INIT;
        ctrl_o.mul_go  = 1'b1;
        ctrl_o.mul_sel = mrp_pkg::MUL_RED;
      end
      mrp_pkg::ST_EXP: begin
        if (!stat_i.e_zero) begin
          ctrl_o.mul_go = 1'b1;
          if (stat_i.e_lsb) begin
            ctrl_o.mul_sel = mrp_pkg::MUL_ACC;
          end else begin
            ctrl_o.mul_sel = mrp_pkg::MUL_SQ;
            ctrl_o.op      = mrp_pkg::OP_SHIFT_E;
          end
        end
      end
      mrp_pkg::ST_ACC_W: begin
        if (!stat_i.mul_busy) begin
          ctrl_o.mul_go  = 1'b1;
          ctrl_o.mul_sel = mrp_pkg::MUL_SQ;
          ctrl_o.op      = mrp_pkg::OP_SHIFT_E;
        end
      end
      mrp_pkg::ST_SQR: begin
        if (!stat_i.j_last) begin
          ctrl_o.mul_go  = 1'b1;
          ctrl_o.mul_sel = mrp_pkg::MUL_X;
          ctrl_o.op      = mrp_pkg::OP_INC_J;
        end
      end
      mrp_pkg::ST_PASS: if (!stat_i.k_last) ctrl_o.op = mrp_pkg::OP_NEXT_BASE;
      mrp_pkg::ST_EMIT0: if (!stat_i.out_busy) ctrl_o.op = mrp_pkg::OP_EMIT;
      mrp_pkg::ST_EMIT1: begin
        if (!stat_i.out_busy) begin
          ctrl_o.op  = mrp_pkg::OP_EMIT;
          ctrl_o.res = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/miller_rabin_primality_32.sv @@
// top level of the deterministic primality tester (bases 2, 7, 61)
// depends on mrp_pkg, mrp_if, mrp_ctrl, mrp_datapath
//
// usage:
//   cand_i carries one WIDTH-bit unsigned candidate per transaction;
//   res_o returns one is_prime bit per candidate, in order.
//   one candidate is processed at a time; cand_i.ready is high only while
//   the block is idle, and it may take a new candidate while the previous
//   result is still held in the output register.
//   0..4 and even values are answered without a modular product; otherwise
//   each base takes up to about 2 * WIDTH modular products, and every
//   modular product runs on one shared bit-serial multiplier.
//   reset clears the controller and drops res_o.valid; no clearing pass.
//   a stalled res_o holds its result, and the block waits before writing
//   the next one.
module miller_rabin_primality_32 #(
  parameter int unsigned WIDTH = mrp_pkg::MRP_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrp_cand_if.sink    cand_i,
  mrp_res_if.source   res_o
);

  mrp_pkg::ctrl_t ctrl;
  mrp_pkg::stat_t stat;

  mrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cand_i.valid),
    .in_ready_o (cand_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  mrp_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cand_i      (cand_i.candidate[WIDTH-1:0]),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .is_prime_o  (res_o.is_prime)
  );

endmodule

@@ hw/rtl/mrp_checker.sv @@
// port-level checker for the primality tester, bound to the top level
// depends on miller_rabin_primality_32_assert.svh
`include "miller_rabin_primality_32_assert.svh"

module mrp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic is_prime_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  `MRP_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `MRP_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(is_prime_i))
  `MRP_ASSERT_NXT(a_one_at_a_time, in_fire, !in_ready_i)
  `MRP_ASSERT_NOW(a_no_instant_result, $rose(out_valid_i), !$past(in_fire))
  `MRP_ASSERT_NOW(a_result_while_busy, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind miller_rabin_primality_32 mrp_checker u_mrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cand_i.valid),
  .in_ready_i  (cand_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .is_prime_i  (res_o.is_prime)
);

@@ verif/miller_rabin_primality_32_tb.sv @@
// testbench for the 32-bit miller-rabin primality tester
// depends on mrp_pkg, mrp_if and miller_rabin_primality_32
// drives candidates with random gaps and stalls, checks every answer in order
module miller_rabin_primality_32_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = mrp_pkg::MRP_WIDTH;

  class prime_scoreboard;
    bit   verdicts_due[$];
    int   errors;

    function bit [31:0] mulmod(bit [31:0] a, bit [31:0] b, bit [31:0] m);
      bit [63:0] p;
      p = 64'(a) * 64'(b);
      return 32'(p % 64'(m));
    endfunction

    function bit [31:0] powmod(bit [31:0] b, bit [31:0] e, bit [31:0] m);
      bit [31:0] acc;
      bit [31:0] sq;
      acc = 1 % m;
      sq = b % m;
      while (e != 0) begin
        if (e[0]) acc = mulmod(acc, sq, m);
        e = e >> 1;
        sq = mulmod(sq, sq, m);
      end
      return acc;
    endfunction

    function bit witness_passes(bit [31:0] n, bit [31:0] a);
      bit [31:0] d;
      bit [31:0] x;
      int        r;
      if (a % n == 0) return 1'b1;
      d = n - 1;
      r = 0;
      while (!d[0]) begin
        d = d >> 1;
        r++;
      end
      x = powmod(a, d, n);
      if (x == 1 || x == n - 1) return 1'b1;
      for (int j = 1; j < r; j++) begin
        x = mulmod(x, x, n);
        if (x == 1) return 1'b0;
        if (x == n - 1) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit is_prime(bit [31:0] n);
      if (n <= 1 || n == 4) return 1'b0;
      if (n <= 3) return 1'b1;
      if (!n[0]) return 1'b0;
      return witness_passes(n, 2) && witness_passes(n, 7) && witness_passes(n, 61);
    endfunction

    function void note_candidate(bit [W-1:0] n);
      verdicts_due.push_back(is_prime(32'(n)));
    endfunction

    function void check_verdict(bit got);
      bit want;
      if (verdicts_due.size() == 0) begin
        $error("is_prime: unexpected transaction, actual %0b", got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $error("is_prime: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  mrp_cand_if #(.WIDTH(W)) cand_i ();
  mrp_res_if               res_o ();

  miller_rabin_primality_32 #(.WIDTH(W)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (cand_i.sink),
    .res_o  (res_o.source)
  );

  prime_scoreboard sb = new();
  int src_idle_pct;
  int snk_idle_pct;
  bit [31:0] directed_cands[$] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 9, 61, 25, 341, 561, 2047, 3215031751,
    4294967291, 4294967295, 4294967294, 2147483647, 2147483648,
    4294967279, 65537, 1373653, 25326001, 3825123056
  };

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_o.valid && res_o.ready) sb.check_verdict(res_o.is_prime);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.ready <= 1'b0;
    end else begin
      res_o.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_candidate(bit [W-1:0] n);
    while ($urandom_range(99) < src_idle_pct) begin
      cand_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    cand_i.valid     <= 1'b1;
    cand_i.candidate <= n;
    do @(posedge clk_i); while (!cand_i.ready);
    sb.note_candidate(n);
  endtask

  function automatic bit [31:0] random_odd_candidate();
    bit [31:0] n;
    case ($urandom_range(3))
      0: n = $urandom_range(1000);
      1: n = $urandom_range(65535);
      default: n = $urandom;
    endcase
    return n | 32'd1;
  endfunction

  initial begin
    cand_i.valid     = 1'b0;
    cand_i.candidate = '0;
    src_idle_pct     = 38;
    snk_idle_pct     = 56;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_cands[i]) send_candidate(directed_cands[i]);
    for (int i = 0; i < 100; i++) begin
      if (i == 33) begin
        src_idle_pct = 56;
        snk_idle_pct = 38;
      end else if (i == 66) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) send_candidate($urandom);
      else send_candidate(random_odd_candidate());
    end
    cand_i.valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/mrp_pkg.sv
hw/rtl/mrp_if.sv
hw/rtl/mrp_datapath.sv
hw/rtl/mrp_ctrl.sv
hw/rtl/miller_rabin_primality_32.sv
hw/rtl/mrp_checker.sv
verif/miller_rabin_primality_32_tb.sv
